/* design/srtx_pkg.sv */
// ----------------------------------------------------------------------------
// srtx_pkg
// Shared types and constants for the serial transmitter register core.
// ----------------------------------------------------------------------------
package srtx_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned CTRL_W  = 6;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned USER_W  = 4;

	// Control register bit positions
	localparam int unsigned CTRL_ENABLE_POS = 0;
	localparam int unsigned CTRL_START_POS  = 1;

	// Status register bit positions
	localparam int unsigned STATUS_BUSY_POS  = 0;
	localparam int unsigned STATUS_DONE_POS  = 1;
	localparam int unsigned STATUS_ERROR_POS = 2;

	localparam logic [DELAY_W-1:0] DELAY_RESET  = 16'd5;
	localparam logic [DATA_W-1:0]  UNMAPPED_VAL = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_INJECT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CTRL     = 2'd0,
		REG_STATUS   = 2'd1,
		REG_TXDATA   = 2'd2,
		REG_UNMAPPED = 2'd3
	} reg_sel_t;

	typedef struct packed {
		cmd_t              cmd;
		reg_sel_t          reg_select;
		logic [DATA_W-1:0] write_data;
	} request_t;

endpackage

/* design/srtx_regs.sv */
// ----------------------------------------------------------------------------
// srtx_regs
// Register file and transfer timer; one request is applied per commit.
// ----------------------------------------------------------------------------
module srtx_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  srtx_pkg::request_t            req,
	input  logic [srtx_pkg::DELAY_W-1:0]  transfer_delay,
	output logic [srtx_pkg::DATA_W-1:0]   read_data
);
	import srtx_pkg::*;

	logic [CTRL_W-1:0]  ctrl_q;
	logic               busy_q, done_q, error_q;
	logic [BYTE_W-1:0]  tx_byte_q;
	logic               tx_loaded_q, armed_q, pending_q, had_byte_q, inject_q;
	logic [DELAY_W-1:0] count_q;

	logic [DATA_W-1:0]  status_word;
	logic [CTRL_W-1:0]  ctrl_clean;
	logic               start_hit;
	logic               tick_done;

	// Flags at coinciding positions simply OR together
	always_comb begin
		status_word = '0;
		status_word[STATUS_BUSY_POS]  = busy_q;
		status_word[STATUS_DONE_POS]  = status_word[STATUS_DONE_POS] | done_q;
		status_word[STATUS_ERROR_POS] = status_word[STATUS_ERROR_POS] | error_q;
	end

	always_comb begin
		read_data = '0;
		if (req.cmd == CMD_READ) begin
			case (req.reg_select)
				REG_CTRL:   read_data = DATA_W'(ctrl_q);
				REG_STATUS: read_data = status_word;
				REG_TXDATA: read_data = DATA_W'(tx_byte_q);
				default:    read_data = UNMAPPED_VAL;
			endcase
		end
	end

	always_comb begin
		ctrl_clean = req.write_data[CTRL_W-1:0];
		ctrl_clean[CTRL_START_POS] = 1'b0;
		start_hit = req.write_data[CTRL_START_POS] && ctrl_clean[CTRL_ENABLE_POS];
		tick_done = pending_q && (count_q <= DELAY_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			error_q     <= 1'b0;
			tx_byte_q   <= '0;
			tx_loaded_q <= 1'b0;
			armed_q     <= 1'b0;
			pending_q   <= 1'b0;
			had_byte_q  <= 1'b0;
			inject_q    <= 1'b0;
			count_q     <= '0;
		end else if (commit) begin
			case (req.cmd)
				CMD_READ: begin
					if (req.reg_select == REG_STATUS) begin
						armed_q <= 1'b1;
					end
				end
				CMD_WRITE: begin
					case (req.reg_select)
						REG_CTRL: begin
							if (armed_q) begin
								ctrl_q <= ctrl_clean;
								if (start_hit) begin
									busy_q      <= 1'b1;
									pending_q   <= 1'b1;
									had_byte_q  <= tx_loaded_q;
									tx_loaded_q <= 1'b0;
									count_q     <= transfer_delay;
								end
							end
						end
						REG_STATUS: begin
							if (req.write_data[STATUS_DONE_POS]) begin
								done_q <= 1'b0;
							end
							if (req.write_data[STATUS_ERROR_POS]) begin
								error_q <= 1'b0;
							end
						end
						REG_TXDATA: begin
							tx_byte_q   <= req.write_data[BYTE_W-1:0];
							tx_loaded_q <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				CMD_TICK: begin
					if (tick_done) begin
						count_q   <= '0;
						busy_q    <= 1'b0;
						pending_q <= 1'b0;
						if (!had_byte_q || inject_q) begin
							error_q  <= 1'b1;
							inject_q <= 1'b0;
						end else begin
							done_q <= 1'b1;
						end
					end else if (pending_q) begin
						count_q <= count_q - DELAY_W'(1);
					end
				end
				default: begin
					inject_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* design/serial_tx_register_device_core.sv */
// ----------------------------------------------------------------------------
// serial_tx_register_device_core
// Bus register model of a one-byte serial transmitter.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on the s_axis channel: tuser carries the command and the
//    register select, tdata the write value. Every request yields exactly one
//    response word on the m_axis channel (read value, or zero).
//  - transfer_delay is loaded through cfg_we/cfg_wdata; write it only while
//    no request is in flight. It resets to 5.
//  - Path: an accepted request waits in the input register and is applied to
//    the register file as it moves into the response register, then valid.
//  - Throughput: one request per cycle when not stalled. The input register
//    and the response register are separate, so a new request is taken while
//    a response waits; all per-request work is one pass of flag and counter logic.
//  - Stall: when m_axis_tready is low the response holds, the input register
//    fills, and s_axis_tready drops until the response is taken.
//  - Reset: register-file state, flags, the timer and the handshake state
//    clear; the write latch starts disarmed.
// ----------------------------------------------------------------------------
module serial_tx_register_device_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request channel
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [srtx_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] write_data
	input  logic [srtx_pkg::USER_W-1:0]   s_axis_tuser,  // [1:0] cmd, [3:2] reg_select
	// Response channel
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [srtx_pkg::DATA_W-1:0]   m_axis_tdata,  // [31:0] read_data
	// Configuration
	input  logic                          cfg_we,
	input  logic [srtx_pkg::DELAY_W-1:0]  cfg_wdata      // transfer_delay
);
	import srtx_pkg::*;

	request_t           req_s1;
	logic               valid_s1;
	logic [DATA_W-1:0]  read_data_s2;
	logic               valid_s2;
	logic [DELAY_W-1:0] delay_q;
	logic [DATA_W-1:0]  read_data;
	logic               advance;

	// Stage 1 moves into the response register when that register is free
	// or being emptied this cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.cmd        <= cmd_t'(s_axis_tuser[1:0]);
			req_s1.reg_select <= reg_sel_t'(s_axis_tuser[3:2]);
			req_s1.write_data <= s_axis_tdata;
		end
	end

	// Register file: state changes on the cycle the request advances
	srtx_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.commit         (advance),
		.req            (req_s1),
		.transfer_delay (delay_q),
		.read_data      (read_data)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= read_data;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = read_data_s2;

endmodule
